>>> hw/rtl/pct_pkg.sv
// pct_pkg: shared types and constants for the prescaled compare timer.
// Used by pct_tick, prescaled_compare_timer and pct_checker; no dependencies.
`default_nettype none

package pct_pkg;

  // Operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Register select codes
  localparam logic [2:0] SEL_CTRL     = 3'd0;
  localparam logic [2:0] SEL_RELOAD   = 3'd1;
  localparam logic [2:0] SEL_CMP0     = 3'd2;
  localparam logic [2:0] SEL_CMP1     = 3'd3;
  localparam logic [2:0] SEL_PRESCALE = 3'd4;
  localparam logic [2:0] SEL_COUNT    = 3'd5;
  localparam logic [2:0] SEL_IRQ      = 3'd6;

  localparam int unsigned PRESCALE_W = 24;

  localparam logic [31:0] CTRL_RESET = 32'h0000_7fff;

  // Control register bits
  localparam int unsigned CTRL_EN_COUNT = 24;
  localparam int unsigned CTRL_LOADZERO = 25;
  localparam int unsigned CTRL_LDM0     = 28;
  localparam int unsigned CTRL_LDM1     = 29;

  // IRQ register bits
  localparam logic [31:0] STAT_MASK      = 32'h0000_3f00;
  localparam int unsigned IRQ_ST_CMP0    = 8;
  localparam int unsigned IRQ_ST_CMP1    = 9;
  localparam int unsigned IRQ_ST_PEND    = 11;
  localparam int unsigned IRQ_EN_CMP0    = 16;
  localparam int unsigned IRQ_EN_CMP1    = 17;
  localparam int unsigned IRQ_EN_PEND    = 19;
  localparam int unsigned IRQ_CLEARMODE  = 31;

  // Timer state touched by a tick
  typedef struct packed {
    logic [PRESCALE_W-1:0] prescale;
    logic [31:0]           count;
    logic [31:0]           irq;
  } tick_upd_t;

endpackage

`default_nettype wire

>>> hw/rtl/pct_tick.sv
// pct_tick: next-state logic for one counter-clock tick (prescaler, main
// counter, status bits). Depends on pct_pkg.
`default_nettype none

module pct_tick (
  input  wire logic [31:0]         ctrl,
  input  wire logic [31:0]         cmp0,
  input  wire logic [31:0]         cmp1,
  input  wire pct_pkg::tick_upd_t  cur,
  output pct_pkg::tick_upd_t       upd
);

  logic [pct_pkg::PRESCALE_W-1:0] limit;
  logic [31:0]                    count_inc;

  assign limit     = ctrl[pct_pkg::PRESCALE_W-1:0];
  assign count_inc = cur.count + 32'd1;

  always_comb begin
    upd = cur;
    if (ctrl[pct_pkg::CTRL_EN_COUNT]) begin
      if (cur.prescale < limit) begin
        upd.prescale = cur.prescale + {{(pct_pkg::PRESCALE_W-1){1'b0}}, 1'b1};
      end else begin
        upd.prescale = '0;
        upd.count    = count_inc;
        if (cur.irq[pct_pkg::IRQ_EN_PEND]) begin
          upd.irq[pct_pkg::IRQ_ST_PEND] = 1'b1;
        end
        if (cur.irq[pct_pkg::IRQ_EN_CMP0] && (count_inc == cmp0)) begin
          upd.irq[pct_pkg::IRQ_ST_CMP0] = 1'b1;
        end
        if (cur.irq[pct_pkg::IRQ_EN_CMP1] && (count_inc == cmp1)) begin
          upd.irq[pct_pkg::IRQ_ST_CMP1] = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/prescaled_compare_timer.sv
// prescaled_compare_timer: top level, register file and result register.
// Depends on pct_pkg and pct_tick.
`default_nettype none

// A 32-bit timer with a 24-bit prescaler and two compare interrupts behind
// seven registers. Each input item is either a counter-clock tick, a
// register read or a register write, and yields exactly one result item
// carrying the read data (zero unless reading), the interrupt line level
// after the item, and a flag for a rejected control write (load-mode bits
// 25, 28 or 29 set). The block takes one item per clock cycle when not
// stalled; the result appears next cycle in a single output register. The
// input is stalled only while that register holds an item the receiver
// is stalling, so a drained result and a new item move in the same cycle.
// All register state updates happen at the edge an item is accepted.
module prescaled_compare_timer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // item input
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [2:0]  in_reg_select,
  input  wire logic [31:0] in_write_data,
  // result output
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [31:0] out_read_data,
  output      logic        out_irq_out,
  output      logic        out_mode_error
);

  logic in_acc;

  // Architectural registers
  logic [31:0]                    ctrl_r,     ctrl_nxt;
  logic [31:0]                    reload_r,   reload_nxt;
  logic [31:0]                    cmp0_r,     cmp0_nxt;
  logic [31:0]                    cmp1_r,     cmp1_nxt;
  logic [pct_pkg::PRESCALE_W-1:0] prescale_r, prescale_nxt;
  logic [31:0]                    count_r,    count_nxt;
  logic [31:0]                    irq_r,      irq_nxt;

  // Result register
  logic        out_valid_r;
  logic [31:0] rd_r, rd_nxt;
  logic        irq_line_r, irq_line_nxt;
  logic        err_r, err_nxt;

  pct_pkg::tick_upd_t tick_cur, tick_upd;

  // Output register frees up when empty or being drained this cycle.
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  assign tick_cur.prescale = prescale_r;
  assign tick_cur.count    = count_r;
  assign tick_cur.irq      = irq_r;

  pct_tick u_tick (
    .ctrl (ctrl_r),
    .cmp0 (cmp0_r),
    .cmp1 (cmp1_r),
    .cur  (tick_cur),
    .upd  (tick_upd)
  );

  always_comb begin
    ctrl_nxt     = ctrl_r;
    reload_nxt   = reload_r;
    cmp0_nxt     = cmp0_r;
    cmp1_nxt     = cmp1_r;
    prescale_nxt = prescale_r;
    count_nxt    = count_r;
    irq_nxt      = irq_r;
    rd_nxt       = '0;
    err_nxt      = 1'b0;

    if (in_acc) begin
      case (in_operation)
        pct_pkg::OP_TICK: begin
          prescale_nxt = tick_upd.prescale;
          count_nxt    = tick_upd.count;
          irq_nxt      = tick_upd.irq;
        end
        pct_pkg::OP_READ: begin
          unique case (in_reg_select)
            pct_pkg::SEL_CTRL:     rd_nxt = ctrl_r;
            pct_pkg::SEL_RELOAD:   rd_nxt = reload_r;
            pct_pkg::SEL_CMP0:     rd_nxt = cmp0_r;
            pct_pkg::SEL_CMP1:     rd_nxt = cmp1_r;
            pct_pkg::SEL_PRESCALE: rd_nxt = {{(32-pct_pkg::PRESCALE_W){1'b0}}, prescale_r};
            pct_pkg::SEL_COUNT:    rd_nxt = count_r;
            pct_pkg::SEL_IRQ: begin
              rd_nxt = irq_r;
              // read-to-clear of status unless clear mode is set
              if (!irq_r[pct_pkg::IRQ_CLEARMODE]) begin
                irq_nxt = irq_r & ~pct_pkg::STAT_MASK;
              end
            end
            default:               rd_nxt = '0;
          endcase
        end
        pct_pkg::OP_WRITE: begin
          unique case (in_reg_select)
            pct_pkg::SEL_CTRL: begin
              if (in_write_data[pct_pkg::CTRL_LOADZERO] ||
                  in_write_data[pct_pkg::CTRL_LDM0] ||
                  in_write_data[pct_pkg::CTRL_LDM1]) begin
                err_nxt = 1'b1;
              end else begin
                ctrl_nxt  = in_write_data;
                count_nxt = '0;
              end
            end
            pct_pkg::SEL_RELOAD: begin
              reload_nxt = in_write_data;
              count_nxt  = '0;
            end
            pct_pkg::SEL_CMP0: cmp0_nxt = in_write_data;
            pct_pkg::SEL_CMP1: cmp1_nxt = in_write_data;
            pct_pkg::SEL_IRQ: begin
              // write-one-to-clear on status, plain storage elsewhere
              irq_nxt = (irq_r & ~in_write_data & pct_pkg::STAT_MASK) |
                        (in_write_data & ~pct_pkg::STAT_MASK);
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    irq_line_nxt = |(irq_nxt[13:8] & irq_nxt[21:16]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= pct_pkg::CTRL_RESET;
      reload_r    <= '0;
      cmp0_r      <= '0;
      cmp1_r      <= '0;
      prescale_r  <= '0;
      count_r     <= '0;
      irq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctrl_r     <= ctrl_nxt;
      reload_r   <= reload_nxt;
      cmp0_r     <= cmp0_nxt;
      cmp1_r     <= cmp1_nxt;
      prescale_r <= prescale_nxt;
      count_r    <= count_nxt;
      irq_r      <= irq_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only with an accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r       <= rd_nxt;
      irq_line_r <= irq_line_nxt;
      err_r      <= err_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = rd_r;
  assign out_irq_out    = irq_line_r;
  assign out_mode_error = err_r;

endmodule

`default_nettype wire

>>> hw/rtl/pct_checker.sv
// pct_checker: port-level assertions for prescaled_compare_timer, bound
// to the top level below. Depends on pct_pkg.
`default_nettype none

module pct_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_operation,
  input wire logic [2:0]  in_reg_select,
  input wire logic [31:0] in_write_data,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_read_data,
  input wire logic        out_mode_error
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) &&
                               $stable(out_mode_error))
    else $error("result changed while stalled");

  // every accepted item shows up as a result next cycle
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  // rejected load mode is flagged
  a_mode_err: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == pct_pkg::OP_WRITE) &&
    (in_reg_select == pct_pkg::SEL_CTRL) &&
    (in_write_data[pct_pkg::CTRL_LOADZERO] || in_write_data[pct_pkg::CTRL_LDM0] ||
     in_write_data[pct_pkg::CTRL_LDM1])
    |=> out_valid && out_mode_error)
    else $error("unsupported load mode not flagged");

  // a flagged write never carries read data
  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_error |-> out_read_data == 32'd0)
    else $error("mode error with nonzero read data");

endmodule

bind prescaled_compare_timer pct_checker u_pct_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_operation   (in_operation),
  .in_reg_select  (in_reg_select),
  .in_write_data  (in_write_data),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_data  (out_read_data),
  .out_mode_error (out_mode_error)
);

`default_nettype wire
